// File: rtl/seed_guided_ground_classifier_assert.svh
// assertion macros shared by the checker
`ifndef SEED_GUIDED_GROUND_CLASSIFIER_ASSERT_SVH
`define SEED_GUIDED_GROUND_CLASSIFIER_ASSERT_SVH
`define SGGC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("implication failed");
`define SGGC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("next-cycle check failed");
`endif

// File: rtl/sggc_pkg.sv
package sggc_pkg;
	localparam int MAX_SEEDS = 1024;
	localparam logic [19:0] HD_SAT = 20'hFFFFF;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_CLASSIFY = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [2:0] ST_GROUND = 3'd0;
	localparam logic [2:0] ST_NO_SEED = 3'd1;
	localparam logic [2:0] ST_HEIGHT = 3'd2;
	localparam logic [2:0] ST_NORMAL = 3'd3;
	localparam logic [2:0] ST_STORED = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;
	localparam logic [2:0] ST_CLEARED = 3'd6;

	localparam logic [2:0] REG_HFE = 3'd0;
	localparam logic [2:0] REG_XY = 3'd1;
	localparam logic [2:0] REG_SPH = 3'd2;
	localparam logic [2:0] REG_HMAX = 3'd3;
	localparam logic [2:0] REG_COS = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE, S_NORM, S_SCAN, S_DRAIN, S_DONE, S_OUT
	} state_t;

	typedef struct packed {
		logic load;      // capture the input word
		logic clr;       // clear seed count
		logic app;       // append seed
		logic norm;      // compute normal products
		logic scan_rd;   // issue a table read
		logic finish;    // form result
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic hfe;
		logic scan_last; // last read issued
		logic pipe_busy; // compares in flight
	} sts_t;
endpackage

// File: rtl/sggc_datapath.sv
module sggc_datapath #(
	parameter int MaxSeeds = sggc_pkg::MAX_SEEDS,
	localparam int AW = (MaxSeeds > 1) ? $clog2(MaxSeeds) : 1,
	localparam int CW = $clog2(MaxSeeds + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  sggc_pkg::cmd_t cmd,
	output sggc_pkg::sts_t sts,
	input  logic [1:0] op,
	input  logic signed [19:0] pos_x,
	input  logic signed [19:0] pos_y,
	input  logic signed [19:0] pos_z,
	input  logic signed [15:0] norm_x,
	input  logic signed [15:0] norm_y,
	input  logic signed [15:0] norm_z,
	input  logic normal_valid,
	input  logic hfe,
	input  logic [39:0] xy_radius_sq,
	input  logic [39:0] sphere_radius_sq,
	input  logic [19:0] height_diff_max,
	input  logic [16:0] normal_cos_sq,
	output logic res_ground,
	output logic [2:0] res_status,
	output logic [19:0] res_best
);
	localparam logic [19:0] HD_SAT_L = sggc_pkg::HD_SAT;

	logic [1:0] op_q;
	logic signed [19:0] px_q, py_q, pz_q;
	logic signed [15:0] nx_q, ny_q, nz_q;
	logic nv_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] rd_idx_q;
	logic [CW-1:0] rd_cnt_q;
	logic [59:0] mem [MaxSeeds];
	logic [59:0] rd_s1;
	logic v_s1, v_s2;
	logic [41:0] dx2_s2, dy2_s2, dz2_s2;
	logic [19:0] h_s2;
	logic found_q;
	logic [19:0] best_q;
	logic [31:0] sx_q, sy_q, sz_q;
	logic [48:0] lhs_q;
	logic [33:0] n2_q;
	logic normok;
	logic [50:0] rhs;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op; px_q <= pos_x; py_q <= pos_y; pz_q <= pos_z;
			nx_q <= norm_x; ny_q <= norm_y; nz_q <= norm_z; nv_q <= normal_valid;
		end
		if (cmd.norm) begin
			sx_q <= 32'(nx_q * nx_q);
			sy_q <= 32'(ny_q * ny_q);
			sz_q <= 32'(nz_q * nz_q);
		end
		n2_q <= 34'(sx_q) + 34'(sy_q) + 34'(sz_q);
		lhs_q <= {1'b0, sz_q[31:0], 16'd0};
	end

	assign rhs = 51'(normal_cos_sq) * 51'(n2_q);
	assign normok = (!nv_q || n2_q == '0) ? (normal_cos_sq == '0) : (51'(lhs_q) >= rhs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_idx_q <= '0;
			rd_cnt_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (cmd.clr) count_q <= '0;
			else if (cmd.app && count_q < CW'(MaxSeeds)) count_q <= count_q + 1'b1;
			if (cmd.load) begin
				rd_idx_q <= '0;
				rd_cnt_q <= '0;
			end else if (cmd.scan_rd) begin
				rd_idx_q <= rd_idx_q + 1'b1;
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			v_s1 <= cmd.scan_rd && rd_cnt_q < count_q;
			v_s2 <= v_s1;
		end
	end

	// seed memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.app && count_q < CW'(MaxSeeds))
			mem[count_q[AW-1:0]] <= {px_q, py_q, pz_q};
		rd_s1 <= mem[rd_idx_q];
	end

	logic signed [20:0] dx, dy, dz;
	logic [20:0] adz;
	assign dx = 21'(px_q) - 21'($signed(rd_s1[59:40]));
	assign dy = 21'(py_q) - 21'($signed(rd_s1[39:20]));
	assign dz = 21'(pz_q) - 21'($signed(rd_s1[19:0]));
	assign adz = dz[20] ? 21'(-dz) : 21'(dz);

	always_ff @(posedge clk) begin
		dx2_s2 <= 42'(dx * dx);
		dy2_s2 <= 42'(dy * dy);
		dz2_s2 <= 42'(dz * dz);
		h_s2 <= adz[20] ? HD_SAT_L : adz[19:0];
	end

	logic [42:0] dxy;
	logic [43:0] d3;
	logic qual;
	assign dxy = 43'(dx2_s2) + 43'(dy2_s2);
	assign d3 = 44'(dxy) + 44'(dz2_s2);
	assign qual = d3 <= 44'(sphere_radius_sq) && 43'(xy_radius_sq) >= dxy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			best_q <= sggc_pkg::HD_SAT;
		end else if (cmd.load) begin
			found_q <= 1'b0;
			best_q <= sggc_pkg::HD_SAT;
		end else if (v_s2 && qual) begin
			found_q <= 1'b1;
			if (h_s2 < best_q) best_q <= h_s2;
		end
	end

	always_comb begin
		res_ground = 1'b0;
		res_best = '0;
		res_status = sggc_pkg::ST_CLEARED;
		unique case (op_q)
			sggc_pkg::OP_CLEAR: res_status = sggc_pkg::ST_CLEARED;
			sggc_pkg::OP_APPEND:
				res_status = (count_q < CW'(MaxSeeds)) ? sggc_pkg::ST_STORED
					: sggc_pkg::ST_FULL;
			default: begin
				if (hfe) res_best = best_q;
				priority if (hfe && !found_q) res_status = sggc_pkg::ST_NO_SEED;
				else if (hfe && best_q > height_diff_max) res_status = sggc_pkg::ST_HEIGHT;
				else if (!normok) res_status = sggc_pkg::ST_NORMAL;
				else begin
					res_status = sggc_pkg::ST_GROUND;
					res_ground = 1'b1;
				end
			end
		endcase
	end

	assign sts.op = op_q;
	assign sts.hfe = hfe;
	assign sts.scan_last = (rd_cnt_q + 1'b1 >= count_q) || (rd_cnt_q >= count_q);
	assign sts.pipe_busy = v_s1 | v_s2;
endmodule

// File: rtl/sggc_ctrl.sv
module sggc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  logic [1:0] op,
	input  sggc_pkg::sts_t sts,
	output sggc_pkg::cmd_t cmd,
	output logic res_load
);
	sggc_pkg::state_t state_q, state_d;
	logic acc;
	assign acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sggc_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sggc_pkg::S_IDLE:
				if (acc && op != sggc_pkg::OP_UNUSED) state_d = sggc_pkg::S_NORM;
			sggc_pkg::S_NORM:
				if (sts.op == sggc_pkg::OP_CLASSIFY && sts.hfe) state_d = sggc_pkg::S_SCAN;
				else state_d = sggc_pkg::S_DRAIN;
			sggc_pkg::S_SCAN: if (sts.scan_last) state_d = sggc_pkg::S_DRAIN;
			sggc_pkg::S_DRAIN: if (!sts.pipe_busy) state_d = sggc_pkg::S_DONE;
			sggc_pkg::S_DONE: state_d = sggc_pkg::S_OUT;
			sggc_pkg::S_OUT: if (!out_stall) state_d = sggc_pkg::S_IDLE;
			default: state_d = sggc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			sggc_pkg::S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = acc;
			end
			sggc_pkg::S_NORM: cmd.norm = 1'b1;
			sggc_pkg::S_SCAN: cmd.scan_rd = 1'b1;
			sggc_pkg::S_DONE: begin
				cmd.finish = 1'b1;
				res_load = 1'b1;
				cmd.clr = sts.op == sggc_pkg::OP_CLEAR;
				cmd.app = sts.op == sggc_pkg::OP_APPEND;
			end
			sggc_pkg::S_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

// File: rtl/seed_guided_ground_classifier.sv
// channel | signals                               | direction
// input   | in_valid, in_stall, op .. normal_valid | into block
// output  | out_valid, out_stall, is_ground..     | out of block
// config  | cfg_we, cfg_index, cfg_data           | into block
// clear/append: IDLE, NORM, DRAIN, DONE and OUT states per word, plus output wait
// classify, filter on: adds a SCAN state that reads the single-port seed table once per stored seed
// classify, filter off: no SCAN state; reset clears seed count and configuration registers, no clearing pass
// out_stall holds the result word; input stalls until it is taken
module seed_guided_ground_classifier #(
	parameter int MaxSeeds = sggc_pkg::MAX_SEEDS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] op,
	input  logic signed [19:0] pos_x,
	input  logic signed [19:0] pos_y,
	input  logic signed [19:0] pos_z,
	input  logic signed [15:0] norm_x,
	input  logic signed [15:0] norm_y,
	input  logic signed [15:0] norm_z,
	input  logic normal_valid,
	output logic out_valid,
	input  logic out_stall,
	output logic is_ground,
	output logic [2:0] status,
	output logic [19:0] best_height_diff,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [39:0] cfg_data
);
	sggc_pkg::cmd_t cmd;
	sggc_pkg::sts_t sts;
	logic hfe_q;
	logic [39:0] xy_q, sph_q;
	logic [19:0] hmax_q;
	logic [16:0] cos_q;
	logic res_load, rg;
	logic [2:0] rs;
	logic [19:0] rb;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hfe_q <= 1'b1;
			xy_q <= 40'd250000;
			sph_q <= 40'd562500;
			hmax_q <= 20'd300;
			cos_q <= 17'd49152;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sggc_pkg::REG_HFE: hfe_q <= cfg_data[0];
				sggc_pkg::REG_XY: xy_q <= cfg_data;
				sggc_pkg::REG_SPH: sph_q <= cfg_data;
				sggc_pkg::REG_HMAX: hmax_q <= cfg_data[19:0];
				sggc_pkg::REG_COS: cos_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	sggc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .op,
		.sts, .cmd, .res_load
	);

	sggc_datapath #(.MaxSeeds(MaxSeeds)) u_dp (
		.clk, .arst_n, .cmd, .sts, .op, .pos_x, .pos_y, .pos_z,
		.norm_x, .norm_y, .norm_z, .normal_valid, .hfe(hfe_q),
		.xy_radius_sq(xy_q), .sphere_radius_sq(sph_q), .height_diff_max(hmax_q),
		.normal_cos_sq(cos_q), .res_ground(rg), .res_status(rs), .res_best(rb)
	);

	// output word register
	always_ff @(posedge clk) begin
		if (res_load) begin
			is_ground <= rg;
			status <= rs;
			best_height_diff <= rb;
		end
	end
endmodule

// File: rtl/sggc_checker.sv
`include "seed_guided_ground_classifier_assert.svh"
module sggc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic is_ground,
	input logic [2:0] status
);
	`SGGC_ASSERT_IMP(a_ground_status, clk, arst_n, out_valid, is_ground == (status == sggc_pkg::ST_GROUND))
	`SGGC_ASSERT_IMP(a_no_accept_busy, clk, arst_n, out_valid, in_stall)
	`SGGC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status))
endmodule

bind seed_guided_ground_classifier sggc_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .is_ground, .status
);
